@@ src/periodic_alarm_table_top_macros.svh @@
// ----------------------------------------------------------------------------
// periodic_alarm_table_top_macros.svh
// Assertion shorthands shared by the alarm table RTL.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_ALARM_TABLE_TOP_MACROS_SVH
`define PERIODIC_ALARM_TABLE_TOP_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define PAT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PAT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/pat_pkg.sv @@
// ----------------------------------------------------------------------------
// pat_pkg
// Types, codes and helpers shared by the alarm table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pat_pkg;

  localparam int unsigned TimeW = 63;
  localparam int unsigned TagW  = 32;

  localparam logic [TimeW-1:0] TIME_MAX = {TimeW{1'b1}};

  typedef logic [2:0] pat_cmd_t;
  localparam pat_cmd_t CMD_ARM_ABS = 3'd0;
  localparam pat_cmd_t CMD_ARM_REL = 3'd1;
  localparam pat_cmd_t CMD_SET_TAG = 3'd2;
  localparam pat_cmd_t CMD_CANCEL  = 3'd3;
  localparam pat_cmd_t CMD_CAN_GRP = 3'd4;
  localparam pat_cmd_t CMD_CHECK   = 3'd5;

  typedef logic [1:0] pat_st_t;
  localparam pat_st_t ST_NONE      = 2'd0;
  localparam pat_st_t ST_SET       = 2'd1;
  localparam pat_st_t ST_CANCELLED = 2'd2;

  typedef logic [1:0] pat_kind_t;
  localparam pat_kind_t KIND_ACK      = 2'd0;
  localparam pat_kind_t KIND_FIRED    = 2'd1;
  localparam pat_kind_t KIND_DEADLINE = 2'd2;

  typedef struct packed {
    pat_st_t          st;
    logic [TimeW-1:0] fire;
    logic [TimeW-1:0] period;
    logic [TagW-1:0]  tag;
    logic             queued;
  } pat_entry_t;

  typedef struct packed {
    pat_kind_t        kind;
    logic [3:0]       slot;
    logic             ok;
    logic [TimeW-1:0] deadline;
    logic             dl_valid;
    logic             last;
  } pat_res_t;

  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                               input logic [TimeW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeW] ? TIME_MAX : s[TimeW-1:0];
  endfunction

  function automatic pat_res_t mk_ack(input logic ok);
    pat_res_t r;
    r          = '0;
    r.kind     = KIND_ACK;
    r.ok       = ok;
    r.last     = 1'b1;
    return r;
  endfunction

  function automatic pat_res_t mk_deadline(input logic [TimeW-1:0] t, input logic v);
    pat_res_t r;
    r          = '0;
    r.kind     = KIND_DEADLINE;
    r.ok       = 1'b1;
    r.deadline = v ? t : '0;
    r.dl_valid = v;
    r.last     = 1'b1;
    return r;
  endfunction

  function automatic pat_res_t mk_fired(input logic [3:0] slot);
    pat_res_t r;
    r      = '0;
    r.kind = KIND_FIRED;
    r.slot = slot;
    r.ok   = 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/pat_mem.sv @@
// ----------------------------------------------------------------------------
// pat_mem
// Slot table: one write and one read port, registered read data, per-entry
// valid bits so that unwritten slots read as all zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module pat_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  re_i,
  input  wire [AW-1:0]         raddr_i,
  input  wire                  we_i,
  input  wire [AW-1:0]         waddr_i,
  input  pat_pkg::pat_entry_t  wdata_i,
  output pat_pkg::pat_entry_t  rdata_o
);
  import pat_pkg::*;

  pat_entry_t       mem_q [DEPTH];
  pat_entry_t       rd_q;
  logic [DEPTH-1:0] vld_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_vld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

@@ src/pat_seq.sv @@
// ----------------------------------------------------------------------------
// pat_seq
// Command sequencer: read-modify-write of one slot per command, or a scan
// over all slots for check (with a running minimum) and group cancel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "periodic_alarm_table_top_macros.svh"

module pat_seq #(
  parameter int unsigned SLOT_COUNT = 16,
  parameter int unsigned AW         = 4
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  // request side
  input  wire                  req_valid_i,
  output logic                 req_ready_o,
  input  wire [2:0]            command_i,
  input  wire [3:0]            slot_i,
  input  wire [62:0]           now_i,
  input  wire [62:0]           start_time_i,
  input  wire [62:0]           delay_i,
  input  wire [62:0]           interval_i,
  input  wire [31:0]           group_value_i,
  // table port
  output logic                 mem_re_o,
  output logic [AW-1:0]        mem_raddr_o,
  output logic                 mem_we_o,
  output logic [AW-1:0]        mem_waddr_o,
  output pat_pkg::pat_entry_t  mem_wdata_o,
  input  pat_pkg::pat_entry_t  mem_rdata_i,
  // result side
  output logic                 res_valid_o,
  input  wire                  res_ready_i,
  output pat_pkg::pat_res_t    res_o
);
  import pat_pkg::*;

  localparam logic [AW-1:0] LastIdx = AW'(SLOT_COUNT - 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_EV   = 5'b00100,
    S_FIN  = 5'b01000,
    S_RES  = 5'b10000
  } pat_state_e;

  pat_state_e       state_q, state_d;
  pat_cmd_t         cmd_q;
  logic [62:0]      now_q, start_q, delay_q, intv_q;
  logic [31:0]      grp_q;
  logic [AW-1:0]    idx_q, idx_d;
  logic             cand_v_q, cand_v_d, best_v_q, best_v_d;
  logic [62:0]      cand_t_q, cand_t_d, best_t_q, best_t_d;
  pat_res_t         res_q, res_d;

  pat_entry_t       e;
  logic             due, periodic, is_set, tag_hit, at_last, take, slot_ok, load;
  logic [62:0]      rearm_t, rel_t;

  assign req_ready_o = (state_q == S_IDLE);
  assign load        = req_valid_i && req_ready_o;
  assign slot_ok     = (32'(slot_i) < SLOT_COUNT);

  assign e        = mem_rdata_i;
  assign is_set   = (e.st == ST_SET);
  assign periodic = (e.period != '0);
  assign due      = e.queued && (e.st != ST_CANCELLED) && (e.fire <= now_q);
  assign tag_hit  = e.queued && is_set && (e.tag == grp_q);
  assign rearm_t  = sat_add(now_q, e.period);
  assign rel_t    = sat_add(now_q, delay_q);
  assign at_last  = (idx_q == LastIdx);
  // fold the previous slot's candidate into the running minimum
  assign take     = cand_v_q && (!best_v_q || (cand_t_q < best_t_q));

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cand_v_d    = cand_v_q;
    cand_t_d    = cand_t_q;
    best_v_d    = best_v_q;
    best_t_d    = best_t_q;
    res_d       = res_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = idx_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q;
    mem_wdata_o = e;
    res_valid_o = 1'b0;
    res_o       = res_q;

    case (state_q)
      S_IDLE: begin
        if (load) begin
          case (command_i)
            CMD_ARM_ABS, CMD_ARM_REL, CMD_SET_TAG, CMD_CANCEL: begin
              if (slot_ok) begin
                idx_d   = AW'(slot_i);
                state_d = S_RD;
              end else begin
                res_d   = mk_ack(1'b0);
                state_d = S_RES;
              end
            end
            CMD_CAN_GRP, CMD_CHECK: begin
              idx_d    = '0;
              cand_v_d = 1'b0;
              best_v_d = 1'b0;
              state_d  = S_RD;
            end
            default: begin
              res_d   = mk_ack(1'b0);
              state_d = S_RES;
            end
          endcase
        end
      end

      S_RD: begin
        mem_re_o = 1'b1;
        if (take) begin
          best_v_d = 1'b1;
          best_t_d = cand_t_q;
        end
        cand_v_d = 1'b0;
        state_d  = S_EV;
      end

      S_EV: begin
        case (cmd_q)
          CMD_ARM_ABS: begin
            mem_we_o    = 1'b1;
            mem_wdata_o = '{st: ST_SET, fire: start_q, period: intv_q,
                            tag: e.tag, queued: 1'b1};
            res_d       = mk_deadline(start_q, 1'b1);
            state_d     = S_RES;
          end
          CMD_ARM_REL: begin
            mem_we_o    = 1'b1;
            mem_wdata_o = '{st: ST_SET, fire: rel_t, period: '0,
                            tag: e.tag, queued: 1'b1};
            res_d       = mk_deadline(rel_t, 1'b1);
            state_d     = S_RES;
          end
          CMD_SET_TAG: begin
            mem_we_o        = 1'b1;
            mem_wdata_o.tag = grp_q;
            res_d           = mk_ack(1'b1);
            state_d         = S_RES;
          end
          CMD_CANCEL: begin
            mem_we_o    = is_set;
            mem_wdata_o = '{st: ST_CANCELLED, fire: '0, period: '0,
                            tag: e.tag, queued: 1'b0};
            res_d       = mk_ack(is_set);
            state_d     = S_RES;
          end
          CMD_CAN_GRP: begin
            mem_we_o    = tag_hit;
            mem_wdata_o = '{st: ST_CANCELLED, fire: '0, period: '0,
                            tag: e.tag, queued: 1'b0};
            if (at_last) begin
              res_d   = mk_ack(1'b1);
              state_d = S_RES;
            end else begin
              idx_d   = idx_q + AW'(1);
              state_d = S_RD;
            end
          end
          CMD_CHECK: begin
            res_o = mk_fired(4'(idx_q));
            // a due slot waits here, unwritten, until its result can go out
            if (!(due && !res_ready_i)) begin
              res_valid_o = due;
              mem_we_o    = due;
              if (periodic) begin
                mem_wdata_o = '{st: ST_SET, fire: rearm_t, period: e.period,
                                tag: e.tag, queued: 1'b1};
              end else begin
                mem_wdata_o = '{st: ST_NONE, fire: '0, period: e.period,
                                tag: e.tag, queued: 1'b0};
              end
              cand_v_d = due ? periodic : (e.queued && is_set);
              cand_t_d = due ? rearm_t : e.fire;
              if (at_last) begin
                state_d = S_FIN;
              end else begin
                idx_d   = idx_q + AW'(1);
                state_d = S_RD;
              end
            end
          end
          default: begin
            res_d   = mk_ack(1'b0);
            state_d = S_RES;
          end
        endcase
      end

      S_FIN: begin
        res_d   = take ? mk_deadline(cand_t_q, 1'b1) : mk_deadline(best_t_q, best_v_q);
        state_d = S_RES;
      end

      S_RES: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cand_v_q <= 1'b0;
      best_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cand_v_q <= cand_v_d;
      best_v_q <= best_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q   <= command_i;
      now_q   <= now_i;
      start_q <= start_time_i;
      delay_q <= delay_i;
      intv_q  <= interval_i;
      grp_q   <= group_value_i;
    end
    idx_q    <= idx_d;
    cand_t_q <= cand_t_d;
    best_t_q <= best_t_d;
    res_q    <= res_d;
  end

  `PAT_ASSERT_IMP(a_no_rw_clash, mem_we_o, !mem_re_o, "table read and write in one cycle")
  `PAT_ASSERT_IMP(a_fire_in_check, res_valid_o && (res_o.kind == KIND_FIRED), (state_q == S_EV) && (cmd_q == CMD_CHECK), "fired result outside check scan")
  `PAT_ASSERT_NXT(a_read_then_eval, state_q == S_RD, state_q == S_EV, "read not followed by evaluation")

endmodule

`default_nettype wire

@@ src/periodic_alarm_table_top.sv @@
// ----------------------------------------------------------------------------
// periodic_alarm_table_top
// Alarm slot table with arm, tag, cancel, group cancel and check commands.
// ----------------------------------------------------------------------------
// One request is taken at a time. Arm, set tag and cancel read, modify and
// write back the slot, then load the result register. Check and group cancel
// walk the whole table through its one read port and one write port, a slot
// at a time; a stalled output holds the walk while a fired alarm waits. The
// output register lets the next request in while the last result is still
// waiting. Per-slot valid bits give the reset contents, so no clearing pass
// runs after reset.
`default_nettype none

`include "periodic_alarm_table_top_macros.svh"

module periodic_alarm_table_top #(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // slot[3:0], now[66:4], start_time[129:67], delay[192:130],
  // interval[255:193], group_value[287:256]
  input  wire [287:0]  s_axis_tdata,
  // command[2:0]
  input  wire [2:0]    s_axis_tuser,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // slot_out[3:0], ok[4], deadline[67:5], deadline_valid[68], zero[71:69]
  output logic [71:0]  m_axis_tdata,
  // kind[1:0]
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast
);
  import pat_pkg::*;

  localparam int unsigned AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic          mem_re, mem_we;
  logic [AW-1:0] mem_raddr, mem_waddr;
  pat_entry_t    mem_wdata, mem_rdata;
  logic          res_valid, res_ready;
  pat_res_t      res;
  logic          out_v_q;
  pat_res_t      out_q;

  pat_mem #(
    .DEPTH (SLOT_COUNT),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  pat_seq #(
    .SLOT_COUNT (SLOT_COUNT),
    .AW         (AW)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (s_axis_tvalid),
    .req_ready_o   (s_axis_tready),
    .command_i     (s_axis_tuser),
    .slot_i        (s_axis_tdata[3:0]),
    .now_i         (s_axis_tdata[66:4]),
    .start_time_i  (s_axis_tdata[129:67]),
    .delay_i       (s_axis_tdata[192:130]),
    .interval_i    (s_axis_tdata[255:193]),
    .group_value_i (s_axis_tdata[287:256]),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_rdata_i   (mem_rdata),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res)
  );

  // output register: free, or emptying this cycle
  assign res_ready = !out_v_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {3'd0, out_q.dl_valid, out_q.deadline, out_q.ok, out_q.slot};
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;

  `PAT_ASSERT_IMP(a_fired_not_last, m_axis_tvalid && (out_q.kind == KIND_FIRED), !out_q.last, "fired result marked last")
  `PAT_ASSERT_NXT(a_res_lands, res_valid && res_ready, out_v_q, "accepted result not held")
  `PAT_ASSERT_IMP(a_idle_no_res, s_axis_tready, !res_valid, "result offered while idle")

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for periodic_alarm_table_top. Requests come from a
// directed table, then random traffic with arm bursts that fill every slot.
// Each accepted request is run through a local copy of the slot table, and
// every reply is compared with the oldest one still pending.
// ----------------------------------------------------------------------------

module tb;
  import pat_pkg::*;

  localparam int unsigned SLOTS        = 16;
  localparam int unsigned RAND_ITEMS   = 80;
  localparam int unsigned MAX_SHOWN    = 10;
  // a full table walk plus the output register, with margin
  localparam int unsigned DRAIN_CYCLES = 2 * SLOTS + 40;

  // command codes the block does not define
  localparam pat_cmd_t CMD_UNDEF_LO = 3'd6;
  localparam pat_cmd_t CMD_UNDEF_HI = 3'd7;

  typedef logic [TimeW-1:0] tick_t;

  typedef struct {
    pat_cmd_t        cmd;
    logic [3:0]      slot;
    tick_t           now;
    tick_t           start;
    tick_t           delay;
    tick_t           interval;
    logic [TagW-1:0] grp;
    bit              fixed;   // reply typed into the table
    pat_res_t        want;
  } alarm_req_t;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  wire          s_axis_tready;
  logic [287:0] s_axis_tdata  = '0;
  logic [2:0]   s_axis_tuser  = '0;
  wire          m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  wire  [71:0]  m_axis_tdata;
  wire  [1:0]   m_axis_tuser;
  wire          m_axis_tlast;

  // local copy of the slot table
  pat_st_t         slot_st     [SLOTS];
  tick_t           slot_fire   [SLOTS];
  tick_t           slot_period [SLOTS];
  logic [TagW-1:0] slot_tag    [SLOTS];
  bit              slot_queued [SLOTS];

  pat_res_t    reply_q[$];
  alarm_req_t  stim_tab[$];
  int unsigned fault_count   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned sent_count    = 0;
  int unsigned total_count   = 1;

  periodic_alarm_table_top #(
    .SLOT_COUNT(SLOTS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5;
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
  end

  function automatic tick_t sat_tick(input tick_t a, input tick_t b);
    if (a > TIME_MAX - b) return TIME_MAX;
    return a + b;
  endfunction

  function automatic pat_res_t mk_reply(input pat_kind_t kind, input logic [3:0] slot,
                                        input logic ok, input tick_t dl, input logic dl_v,
                                        input logic last);
    pat_res_t r;
    r.kind     = kind;
    r.slot     = slot;
    r.ok       = ok;
    r.deadline = dl;
    r.dl_valid = dl_v;
    r.last     = last;
    return r;
  endfunction

  function automatic bit drop_slot(input int s);
    if (slot_st[s] != ST_SET) return 1'b0;
    slot_st[s]     = ST_CANCELLED;
    slot_fire[s]   = '0;
    slot_period[s] = '0;
    slot_queued[s] = 1'b0;
    return 1'b1;
  endfunction

  // apply one request to the local table and queue the replies it causes
  function automatic void run_alarm_cmd(input alarm_req_t r);
    tick_t best;
    bit    have;
    best = '0;
    have = 1'b0;
    case (r.cmd)
      CMD_ARM_ABS, CMD_ARM_REL: begin
        slot_fire[r.slot]   = (r.cmd == CMD_ARM_ABS) ? r.start : sat_tick(r.now, r.delay);
        slot_period[r.slot] = (r.cmd == CMD_ARM_ABS) ? r.interval : '0;
        slot_st[r.slot]     = ST_SET;
        slot_queued[r.slot] = 1'b1;
        reply_q.push_back(mk_reply(KIND_DEADLINE, 4'd0, 1'b1, slot_fire[r.slot], 1'b1, 1'b1));
      end
      CMD_SET_TAG: begin
        slot_tag[r.slot] = r.grp;
        reply_q.push_back(mk_reply(KIND_ACK, 4'd0, 1'b1, '0, 1'b0, 1'b1));
      end
      CMD_CANCEL: begin
        reply_q.push_back(mk_reply(KIND_ACK, 4'd0, drop_slot(r.slot), '0, 1'b0, 1'b1));
      end
      CMD_CAN_GRP: begin
        for (int s = 0; s < SLOTS; s++)
          if (slot_queued[s] && slot_tag[s] == r.grp) void'(drop_slot(s));
        reply_q.push_back(mk_reply(KIND_ACK, 4'd0, 1'b1, '0, 1'b0, 1'b1));
      end
      CMD_CHECK: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (slot_queued[s] && slot_st[s] != ST_CANCELLED && slot_fire[s] <= r.now) begin
            if (slot_period[s] != '0) begin
              slot_fire[s] = sat_tick(r.now, slot_period[s]);
              slot_st[s]   = ST_SET;
            end else begin
              slot_fire[s]   = '0;
              slot_st[s]     = ST_NONE;
              slot_queued[s] = 1'b0;
            end
            reply_q.push_back(mk_reply(KIND_FIRED, s[3:0], 1'b1, '0, 1'b0, 1'b0));
          end
        end
        for (int s = 0; s < SLOTS; s++) begin
          if (slot_queued[s] && slot_st[s] == ST_SET && (!have || slot_fire[s] < best)) begin
            best = slot_fire[s];
            have = 1'b1;
          end
        end
        reply_q.push_back(mk_reply(KIND_DEADLINE, 4'd0, 1'b1, best, have, 1'b1));
      end
      default: begin
        reply_q.push_back(mk_reply(KIND_ACK, 4'd0, 1'b0, '0, 1'b0, 1'b1));
      end
    endcase
  endfunction

  function automatic tick_t rand_wide();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TimeW-1:0];
  endfunction

  // mostly near the running time base, so that checks fire something
  function automatic tick_t rand_tick(input tick_t base);
    case ($urandom_range(9))
      0:       return rand_wide();
      1:       return TIME_MAX;
      2:       return '0;
      default: return base + $urandom_range(300);
    endcase
  endfunction

  function automatic tick_t rand_span();
    case ($urandom_range(9))
      0:       return rand_wide();
      1:       return TIME_MAX;
      2, 3:    return '0;
      default: return tick_t'($urandom_range(1, 200));
    endcase
  endfunction

  function automatic alarm_req_t rand_req(input tick_t base);
    alarm_req_t  r;
    int unsigned w;
    w = $urandom_range(99);
    if      (w < 24) r.cmd = CMD_ARM_ABS;
    else if (w < 38) r.cmd = CMD_ARM_REL;
    else if (w < 48) r.cmd = CMD_SET_TAG;
    else if (w < 62) r.cmd = CMD_CANCEL;
    else if (w < 70) r.cmd = CMD_CAN_GRP;
    else if (w < 95) r.cmd = CMD_CHECK;
    else             r.cmd = (w % 2) ? CMD_UNDEF_HI : CMD_UNDEF_LO;
    r.slot     = 4'($urandom_range(15));
    r.now      = rand_tick(base);
    r.start    = rand_tick(base);
    r.delay    = rand_span();
    r.interval = rand_span();
    r.grp      = ($urandom_range(3) == 0) ? $urandom : $urandom_range(3);
    r.fixed    = 1'b0;
    r.want     = '0;
    return r;
  endfunction

  task automatic add_row(input pat_cmd_t cmd, input logic [3:0] slot, input tick_t now,
                         input tick_t start, input tick_t delay, input tick_t interval,
                         input logic [TagW-1:0] grp, input bit fixed, input pat_res_t want);
    alarm_req_t r;
    r.cmd      = cmd;
    r.slot     = slot;
    r.now      = now;
    r.start    = start;
    r.delay    = delay;
    r.interval = interval;
    r.grp      = grp;
    r.fixed    = fixed;
    r.want     = want;
    stim_tab.push_back(r);
  endtask

  task automatic send_alarm_req(input alarm_req_t r);
    int unsigned third;
    int unsigned gap;
    third = (sent_count * 3) / total_count;
    send_idle_pct = (third == 0) ? 37 : (third == 1) ? 88 : 0;
    recv_idle_pct = (third == 0) ? 88 : (third == 1) ? 37 : 0;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r.grp, r.interval, r.delay, r.start, r.now, r.slot};
    s_axis_tuser  <= r.cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    run_alarm_cmd(r);
    // typed rows are single-reply: swap in the hand-written reply
    if (r.fixed) begin
      void'(reply_q.pop_back());
      reply_q.push_back(r.want);
    end
    sent_count++;
  endtask

  initial begin
    alarm_req_t  r;
    tick_t       base;
    int unsigned i;
    pat_res_t    no_dl;
    pat_res_t    ack_ok;
    pat_res_t    ack_bad;

    for (int s = 0; s < SLOTS; s++) begin
      slot_st[s]     = ST_NONE;
      slot_fire[s]   = '0;
      slot_period[s] = '0;
      slot_tag[s]    = '0;
      slot_queued[s] = 1'b0;
    end

    no_dl   = mk_reply(KIND_DEADLINE, 4'd0, 1'b1, '0, 1'b0, 1'b1);
    ack_ok  = mk_reply(KIND_ACK, 4'd0, 1'b1, '0, 1'b0, 1'b1);
    ack_bad = mk_reply(KIND_ACK, 4'd0, 1'b0, '0, 1'b0, 1'b1);

    // cmd, slot, now, start, delay, interval, group, typed, reply
    add_row(CMD_CHECK,    4'd0,  '0, '0, '0, '0, '0, 1'b1, no_dl);
    add_row(CMD_CANCEL,   4'd3,  '0, '0, '0, '0, '0, 1'b1, ack_bad);
    add_row(CMD_UNDEF_LO, 4'd0,  '0, '0, '0, '0, '0, 1'b1, ack_bad);
    add_row(CMD_UNDEF_HI, 4'd15, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX, '1, 1'b1, ack_bad);
    add_row(CMD_ARM_ABS,  4'd0,  '0, 63'd100, '0, 63'd50, '0, 1'b1,
            mk_reply(KIND_DEADLINE, 4'd0, 1'b1, 63'd100, 1'b1, 1'b1));
    add_row(CMD_ARM_ABS,  4'd15, '0, TIME_MAX, '0, TIME_MAX, '0, 1'b1,
            mk_reply(KIND_DEADLINE, 4'd0, 1'b1, TIME_MAX, 1'b1, 1'b1));
    // relative arm past the end of time saturates
    add_row(CMD_ARM_REL,  4'd1,  TIME_MAX, '0, TIME_MAX, '0, '0, 1'b1,
            mk_reply(KIND_DEADLINE, 4'd0, 1'b1, TIME_MAX, 1'b1, 1'b1));
    add_row(CMD_ARM_REL,  4'd2,  63'd10, '0, 63'd5, '0, '0, 1'b1,
            mk_reply(KIND_DEADLINE, 4'd0, 1'b1, 63'd15, 1'b1, 1'b1));
    add_row(CMD_ARM_REL,  4'd3,  63'd40, '0, '0, '0, '0, 1'b1,
            mk_reply(KIND_DEADLINE, 4'd0, 1'b1, 63'd40, 1'b1, 1'b1));
    add_row(CMD_SET_TAG,  4'd1,  '0, '0, '0, '0, '1, 1'b1, ack_ok);
    add_row(CMD_SET_TAG,  4'd3,  '0, '0, '0, '0, '1, 1'b1, ack_ok);
    add_row(CMD_CHECK,    4'd0,  63'd100, '0, '0, '0, '0, 1'b0, '0);
    add_row(CMD_CAN_GRP,  4'd0,  '0, '0, '0, '0, '1, 1'b1, ack_ok);
    add_row(CMD_CANCEL,   4'd1,  '0, '0, '0, '0, '0, 1'b1, ack_bad);
    add_row(CMD_CANCEL,   4'd0,  '0, '0, '0, '0, '0, 1'b1, ack_ok);
    add_row(CMD_CANCEL,   4'd0,  '0, '0, '0, '0, '0, 1'b1, ack_bad);
    add_row(CMD_ARM_ABS,  4'd5,  '0, '0, '0, '0, '0, 1'b1,
            mk_reply(KIND_DEADLINE, 4'd0, 1'b1, '0, 1'b1, 1'b1));
    add_row(CMD_CHECK,    4'd0,  '0, '0, '0, '0, '0, 1'b0, '0);
    // periodic rearm at the end of time saturates
    add_row(CMD_CHECK,    4'd0,  TIME_MAX, '0, '0, '0, '0, 1'b0, '0);
    add_row(CMD_CAN_GRP,  4'd0,  '0, '0, '0, '0, '0, 1'b1, ack_ok);
    add_row(CMD_CHECK,    4'd0,  TIME_MAX, '0, '0, '0, '0, 1'b1, no_dl);
    add_row(CMD_SET_TAG,  4'd0,  '0, '0, '0, '0, '0, 1'b1, ack_ok);

    total_count = stim_tab.size() + RAND_ITEMS;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_tab[k]) send_alarm_req(stim_tab[k]);

    base = 63'd1000;
    i    = 0;
    while (i < RAND_ITEMS) begin
      if (i == 30 || i == 65) begin
        // fill the whole table, then one check that fires most of it
        for (int s = 0; s < SLOTS; s++) begin
          r          = rand_req(base);
          r.cmd      = CMD_ARM_ABS;
          r.slot     = s[3:0];
          r.start    = base + $urandom_range(40);
          r.interval = $urandom_range(1) ? tick_t'($urandom_range(1, 60)) : '0;
          send_alarm_req(r);
        end
        r     = rand_req(base);
        r.cmd = CMD_CHECK;
        r.now = base + 63'd50;
        send_alarm_req(r);
        base = base + 63'd50;
        i    = i + SLOTS + 1;
      end else begin
        r = rand_req(base);
        if (r.cmd == CMD_CHECK) begin
          if ($urandom_range(7) != 0) r.now = base;
          base = base + $urandom_range(150);
        end
        send_alarm_req(r);
        i++;
      end
    end
    s_axis_tvalid <= 1'b0;

    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fault_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // reply side: random back-pressure, compare in order
  initial begin
    pat_res_t got;
    pat_res_t want;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind     = m_axis_tuser;
        got.slot     = m_axis_tdata[3:0];
        got.ok       = m_axis_tdata[4];
        got.deadline = m_axis_tdata[67:5];
        got.dl_valid = m_axis_tdata[68];
        got.last     = m_axis_tlast;
        if (reply_q.size() == 0) begin
          fault_count++;
          if (fault_count <= MAX_SHOWN) begin
            $display("%0t: reply with nothing pending", $realtime);
            $display("  got kind %0d slot %0d ok %0b dl %0h v %0b last %0b",
                     got.kind, got.slot, got.ok, got.deadline, got.dl_valid, got.last);
          end
        end else begin
          want = reply_q.pop_front();
          if (got !== want) begin
            fault_count++;
            if (fault_count <= MAX_SHOWN) begin
              $display("%0t: reply mismatch", $realtime);
              $display("  exp kind %0d slot %0d ok %0b dl %0h v %0b last %0b",
                       want.kind, want.slot, want.ok, want.deadline, want.dl_valid,
                       want.last);
              $display("  got kind %0d slot %0d ok %0b dl %0h v %0b last %0b",
                       got.kind, got.slot, got.ok, got.deadline, got.dl_valid, got.last);
            end
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
